@@ hdl/assert_macros.svh @@
// Shared assertion macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/g2e_pkg.sv @@
`timescale 1ns / 1ps
package g2e_pkg;

    localparam int TRIG_ITERATIONS = 32;
    localparam int LATENCY         = TRIG_ITERATIONS + 75;
    localparam int SQRT_STEPS      = 32;
    localparam int DIV_STEPS       = 31;

    typedef logic signed [43:0] t_ang;
    typedef t_ang t_atab [TRIG_ITERATIONS];

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
        logic signed [31:0] height;
    } t_geo_in;

    typedef struct packed {
        logic signed [39:0] ecef_x;
        logic signed [39:0] ecef_y;
        logic signed [39:0] ecef_z;
    } t_geo_out;

    typedef struct packed {
        t_ang x;
        t_ang y;
        t_ang z;
    } t_rot;

    typedef struct packed {
        t_ang               clat;
        t_ang               slat;
        t_ang               clon;
        t_ang               slon;
        logic signed [31:0] h;
    } t_side;

    typedef struct packed {
        logic        neg;
        logic [64:0] lo;
        logic [63:0] hi;
    } t_pp;

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } t_sqs;

    typedef struct packed {
        logic [63:0] rem;
        logic [31:0] den;
        logic [30:0] q;
    } t_dvs;

    // Elaboration-time helpers
    function automatic logic [63:0] cdiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r    = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] atan_inv(input logic [63:0] n);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] nn;
        logic [63:0] k;
        t   = cdiv(64'd1 << 62, n);
        sum = t;
        nn  = n * n;
        k   = 64'd1;
        while (t != 0) begin
            t = cdiv(t, nn);
            if (k[0]) begin
                sum = sum - cdiv(t, 2 * k + 1);
            end else begin
                sum = sum + cdiv(t, 2 * k + 1);
            end
            k = k + 1;
        end
        return sum;
    endfunction

    function automatic logic [63:0] atan_pow2(input int i);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] k;
        int          sh;
        t   = 64'd1 << (62 - i);
        sum = t;
        k   = 64'd1;
        sh  = 2 * i;
        if (sh < 64) begin
            t = t >> sh;
            while (t != 0) begin
                if (k[0]) begin
                    sum = sum - cdiv(t, 2 * k + 1);
                end else begin
                    sum = sum + cdiv(t, 2 * k + 1);
                end
                k = k + 1;
                t = t >> sh;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = '0;
        bt  = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        if (v > res) begin
            res = res + 1;
        end
        return res;
    endfunction

    function automatic logic [63:0] frac_c(input logic [63:0] num, input logic [63:0] den,
                                           input int bits);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = num;
        for (int b = 0; b < bits; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= den) begin
            q = q + 1;
        end
        return q;
    endfunction

    function automatic logic [63:0] gain_c();
        logic [63:0] g;
        g = 64'd1 << 63;
        for (int i = 1; i < TRIG_ITERATIONS; i++) begin
            if (2 * i < 64) begin
                g = g + (g >> (2 * i));
            end
        end
        return frac_c(64'd1 << 31, isqrt_c(g), 40);
    endfunction

    localparam logic [63:0] PI4 = (atan_inv(64'd5) << 2) - atan_inv(64'd239);

    function automatic t_atab atan_table();
        t_atab t;
        t[0] = t_ang'((PI4 + (64'd1 << 21)) >> 22);
        for (int i = 1; i < TRIG_ITERATIONS; i++) begin
            t[i] = t_ang'((atan_pow2(i) + (64'd1 << 21)) >> 22);
        end
        return t;
    endfunction

    localparam t_ang        PI_Q     = t_ang'((PI4 + (64'd1 << 19)) >> 20);
    localparam t_ang        HALF_Q   = t_ang'((PI4 + (64'd1 << 20)) >> 21);
    localparam t_atab       ATAN_TAB = atan_table();
    localparam t_ang        KQ       = t_ang'(gain_c());
    localparam t_ang        ECC_Q    = t_ang'(frac_c(64'd818191908426, 64'd10000000000000, 40));
    localparam t_ang        OME2_Q   =
        t_ang'(frac_c(64'd99330562000987, 64'd100000000000000, 40));
    localparam logic [63:0] A_SHIFT  = 64'd6378137 << 39;
    localparam logic [63:0] ONE_62   = 64'd1 << 62;

    // Run-time datapath helpers
    function automatic t_rot rot_step(input t_rot a, input int k, input t_ang ang);
        t_rot r;
        if (!a.z[43]) begin
            r.x = a.x - (a.y >>> k);
            r.y = a.y + (a.x >>> k);
            r.z = a.z - ang;
        end else begin
            r.x = a.x + (a.y >>> k);
            r.y = a.y - (a.x >>> k);
            r.z = a.z + ang;
        end
        return r;
    endfunction

    function automatic t_pp mul_pp(input t_ang a, input t_ang b);
        logic [42:0] ma;
        logic [42:0] mb;
        t_pp         p;
        ma    = a[43] ? 43'(-a) : a[42:0];
        mb    = b[43] ? 43'(-b) : b[42:0];
        p.neg = a[43] ^ b[43];
        p.lo  = {22'd0, ma} * {43'd0, mb[21:0]};
        p.hi  = {21'd0, ma} * {43'd0, mb[42:22]};
        return p;
    endfunction

    // Round half away from zero after shift by s
    function automatic logic signed [63:0] mul_fin(input t_pp p, input int s);
        logic [85:0] sum;
        logic [62:0] m;
        sum = {21'd0, p.lo} + {p.hi, 22'd0} + (86'd1 << (s - 1));
        m   = 63'(sum >> s);
        return p.neg ? -signed'({1'b0, m}) : signed'({1'b0, m});
    endfunction

    function automatic t_sqs sqrt_step(input t_sqs a, input int k);
        logic [63:0] bt;
        t_sqs        r;
        bt = 64'd1 << (62 - 2 * k);
        if (a.x >= a.r + bt) begin
            r.x = a.x - (a.r + bt);
            r.r = (a.r >> 1) + bt;
        end else begin
            r.x = a.x;
            r.r = a.r >> 1;
        end
        return r;
    endfunction

    function automatic t_dvs div_step(input t_dvs a, input int i);
        logic [63:0] trial;
        t_dvs        r;
        trial = 64'(a.den) << i;
        r     = a;
        if (a.rem >= trial) begin
            r.rem  = a.rem - trial;
            r.q[i] = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ hdl/g2e_cordic.sv @@
`timescale 1ns / 1ps
module g2e_cordic import g2e_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_ang               i_lat,
    input  t_ang               i_lon,
    input  logic signed [31:0] i_h,
    output logic               o_valid,
    output t_side              o_side
);

    logic               r_v    [TRIG_ITERATIONS + 1];
    t_rot               r_lat  [TRIG_ITERATIONS + 1];
    t_rot               r_lon  [TRIG_ITERATIONS + 1];
    logic               r_flat [TRIG_ITERATIONS + 1];
    logic               r_flon [TRIG_ITERATIONS + 1];
    logic signed [31:0] r_h    [TRIG_ITERATIONS + 1];

    t_rot n_lat;
    t_rot n_lon;
    logic n_flat;
    logic n_flon;

    // quarter-turn fold
    always_comb begin
        n_lat.x = KQ;
        n_lat.y = '0;
        n_lon.x = KQ;
        n_lon.y = '0;
        n_flat  = 1'b0;
        n_flon  = 1'b0;
        n_lat.z = i_lat;
        n_lon.z = i_lon;
        if (i_lat > HALF_Q) begin
            n_lat.z = i_lat - PI_Q;
            n_flat  = 1'b1;
        end else if (i_lat < -HALF_Q) begin
            n_lat.z = i_lat + PI_Q;
            n_flat  = 1'b1;
        end
        if (i_lon > HALF_Q) begin
            n_lon.z = i_lon - PI_Q;
            n_flon  = 1'b1;
        end else if (i_lon < -HALF_Q) begin
            n_lon.z = i_lon + PI_Q;
            n_flon  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lat[0]  <= n_lat;
        r_lon[0]  <= n_lon;
        r_flat[0] <= n_flat;
        r_flon[0] <= n_flon;
        r_h[0]    <= i_h;
    end

    for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k + 1] <= 1'b0;
            end else begin
                r_v[k + 1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_lat[k + 1]  <= rot_step(r_lat[k], k, ATAN_TAB[k]);
            r_lon[k + 1]  <= rot_step(r_lon[k], k, ATAN_TAB[k]);
            r_flat[k + 1] <= r_flat[k];
            r_flon[k + 1] <= r_flon[k];
            r_h[k + 1]    <= r_h[k];
        end
    end

    assign o_valid     = r_v[TRIG_ITERATIONS];
    assign o_side.clat = r_flat[TRIG_ITERATIONS] ? -r_lat[TRIG_ITERATIONS].x
                                                 : r_lat[TRIG_ITERATIONS].x;
    assign o_side.slat = r_flat[TRIG_ITERATIONS] ? -r_lat[TRIG_ITERATIONS].y
                                                 : r_lat[TRIG_ITERATIONS].y;
    assign o_side.clon = r_flon[TRIG_ITERATIONS] ? -r_lon[TRIG_ITERATIONS].x
                                                 : r_lon[TRIG_ITERATIONS].x;
    assign o_side.slon = r_flon[TRIG_ITERATIONS] ? -r_lon[TRIG_ITERATIONS].y
                                                 : r_lon[TRIG_ITERATIONS].y;
    assign o_side.h    = r_h[TRIG_ITERATIONS];

endmodule

@@ hdl/geodetic_to_ecef.sv @@
// Throughput: one beat per cycle; busy is held low, every start is taken.
// Depth set by the CORDIC stages, the multiply stages, the 32-step root and the 31-step divider.
// Results appear for one cycle on o_done; the receiver cannot stall.
// Synchronous active-low reset clears all valid bits; data registers are not reset.
`timescale 1ns / 1ps
module geodetic_to_ecef import g2e_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_geo_in  i_pos,
    output logic     o_done,
    output t_geo_out o_ecef
);

    logic  c_v;
    t_side c_side;

    logic  r_a1_v;
    t_side r_a1_side;
    t_pp   r_a1_pp;
    logic  r_a2_v;
    t_side r_a2_side;
    t_ang  r_a2_d;
    logic  r_a3_v;
    t_side r_a3_side;
    t_pp   r_a3_pp;

    logic  r_sq_v    [SQRT_STEPS + 1];
    t_sqs  r_sq      [SQRT_STEPS + 1];
    t_side r_sq_side [SQRT_STEPS + 1];

    logic        r_rt_v;
    logic [31:0] r_rt;
    t_side       r_rt_side;

    logic  r_dv_v    [DIV_STEPS + 1];
    t_dvs  r_dv      [DIV_STEPS + 1];
    t_side r_dv_side [DIV_STEPS + 1];

    logic               r_p1_v;
    t_side              r_p1_side;
    logic signed [33:0] r_p1_nph;
    t_pp                r_p1_pp;
    logic               r_p2_v;
    t_side              r_p2_side;
    t_ang               r_p2_zt;
    t_pp                r_p2_pp;
    logic               r_p3_v;
    t_side              r_p3_side;
    t_ang               r_p3_zt;
    t_ang               r_p3_tmp;
    logic               r_p4_v;
    t_pp                r_p4_ppx;
    t_pp                r_p4_ppy;
    t_pp                r_p4_ppz;
    logic               r_done;
    t_geo_out           r_out;

    logic signed [63:0] n_d;
    logic signed [63:0] n_d2;
    logic        [63:0] n_rt;
    logic signed [63:0] n_zt;
    logic signed [63:0] n_tmp;
    logic signed [63:0] n_x;
    logic signed [63:0] n_y;
    logic signed [63:0] n_z;

    assign busy = 1'b0;

    g2e_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_lat   (t_ang'(i_pos.latitude) <<< 11),
        .i_lon   (t_ang'(i_pos.longitude) <<< 11),
        .i_h     (i_pos.height),
        .o_valid (c_v),
        .o_side  (c_side)
    );

    assign n_d   = mul_fin(r_a1_pp, 40);
    assign n_d2  = mul_fin(r_a3_pp, 18);
    assign n_rt  = (r_sq[SQRT_STEPS].x > r_sq[SQRT_STEPS].r) ? r_sq[SQRT_STEPS].r + 64'd1
                                                             : r_sq[SQRT_STEPS].r;
    assign n_zt  = mul_fin(r_p1_pp, 40);
    assign n_tmp = mul_fin(r_p2_pp, 40);
    assign n_x   = mul_fin(r_p4_ppx, 40);
    assign n_y   = mul_fin(r_p4_ppy, 40);
    assign n_z   = mul_fin(r_p4_ppz, 40);

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_v    <= 1'b0;
            r_a2_v    <= 1'b0;
            r_a3_v    <= 1'b0;
            r_sq_v[0] <= 1'b0;
            r_rt_v    <= 1'b0;
            r_dv_v[0] <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p3_v    <= 1'b0;
            r_p4_v    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_a1_v    <= c_v;
            r_a2_v    <= r_a1_v;
            r_a3_v    <= r_a2_v;
            r_sq_v[0] <= r_a3_v;
            r_rt_v    <= r_sq_v[SQRT_STEPS];
            r_dv_v[0] <= r_rt_v;
            r_p1_v    <= r_dv_v[DIV_STEPS];
            r_p2_v    <= r_p1_v;
            r_p3_v    <= r_p2_v;
            r_p4_v    <= r_p3_v;
            r_done    <= r_p4_v;
        end
    end

    // e * sin(lat), then its square, then 1 - d^2
    always_ff @(posedge i_clk) begin
        r_a1_side    <= c_side;
        r_a1_pp      <= mul_pp(ECC_Q, c_side.slat);
        r_a2_side    <= r_a1_side;
        r_a2_d       <= n_d[43:0];
        r_a3_side    <= r_a2_side;
        r_a3_pp      <= mul_pp(r_a2_d, r_a2_d);
        r_sq_side[0] <= r_a3_side;
        r_sq[0].x    <= ONE_62 - unsigned'(n_d2);
        r_sq[0].r    <= '0;
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k + 1] <= 1'b0;
            end else begin
                r_sq_v[k + 1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq[k + 1]      <= sqrt_step(r_sq[k], k);
            r_sq_side[k + 1] <= r_sq_side[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rt         <= n_rt[31:0];
        r_rt_side    <= r_sq_side[SQRT_STEPS];
        r_dv[0].rem  <= A_SHIFT + 64'(r_rt >> 1);
        r_dv[0].den  <= r_rt;
        r_dv[0].q    <= '0;
        r_dv_side[0] <= r_rt_side;
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j + 1] <= 1'b0;
            end else begin
                r_dv_v[j + 1] <= r_dv_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[j + 1]      <= div_step(r_dv[j], DIV_STEPS - 1 - j);
            r_dv_side[j + 1] <= r_dv_side[j];
        end
    end

    // N + h, (1-e^2)N + h, and the final products
    always_ff @(posedge i_clk) begin
        r_p1_side <= r_dv_side[DIV_STEPS];
        r_p1_nph  <= 34'(r_dv[DIV_STEPS].q) + 34'(r_dv_side[DIV_STEPS].h);
        r_p1_pp   <= mul_pp(t_ang'({13'd0, r_dv[DIV_STEPS].q}), OME2_Q);
        r_p2_side <= r_p1_side;
        r_p2_zt   <= n_zt[43:0] + t_ang'(r_p1_side.h);
        r_p2_pp   <= mul_pp(t_ang'(r_p1_nph), r_p1_side.clat);
        r_p3_side <= r_p2_side;
        r_p3_zt   <= r_p2_zt;
        r_p3_tmp  <= n_tmp[43:0];
        r_p4_ppx  <= mul_pp(r_p3_tmp, r_p3_side.clon);
        r_p4_ppy  <= mul_pp(r_p3_tmp, r_p3_side.slon);
        r_p4_ppz  <= mul_pp(r_p3_zt, r_p3_side.slat);
        r_out.ecef_x <= n_x[39:0];
        r_out.ecef_y <= n_y[39:0];
        r_out.ecef_z <= n_z[39:0];
    end

    assign o_done = r_done;
    assign o_ecef = r_out;

endmodule

@@ hdl/g2e_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module g2e_checker import g2e_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_geo_in  i_pos,
    input logic     o_done,
    input t_geo_out o_ecef
);

    `ASSERT_NEVER(a_never_busy, i_clk, i_rst_n, busy, "busy raised")

    `ASSERT_HOLDS(a_beat_out, i_clk, i_rst_n, start |-> ##LATENCY o_done, "result beat missing")

    `ASSERT_HOLDS(a_no_spurious, i_clk, i_rst_n, o_done |-> $past(start, LATENCY), "spurious result beat")

    `ASSERT_HOLDS(a_stateless, i_clk, i_rst_n, (o_done && $past(o_done) && ($past(i_pos, LATENCY) == $past(i_pos, LATENCY + 1))) |-> (o_ecef == $past(o_ecef)), "same position gave different result")

endmodule

bind geodetic_to_ecef g2e_checker u_g2e_checker (.*);
